>>> design/rsc_pkg.sv
// ----------------------------------------------------------------------------
// Radix string calculator package
// Shared types, codes and digit helpers.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    localparam logic [1:0] CMD_FIRST   = 2'd0;
    localparam logic [1:0] CMD_SECOND  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [1:0] operator_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
        logic       error_flag;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // latch item, take char or start compute setup
        logic calc;        // compute result of add/sub/mul, or finish divide
        logic div_step;    // one restoring divide step
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_compute;
        logic is_div;
        logic error;
        logic res_zero;
        logic res_neg;
        logic div_done;
        logic last_digit;
    } dp_stat_t;

    function automatic logic [2:0] digit_bits(input logic [1:0] base);
        case (base)
            BASE_BIN: digit_bits = 3'd1;
            BASE_OCT: digit_bits = 3'd3;
            default:  digit_bits = 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
            digit_char = CH_ZERO + {4'd0, d};
        else
            digit_char = CH_UA + {4'd0, d} - 8'd10;
    endfunction

endpackage

>>> design/rsc_datapath.sv
// ----------------------------------------------------------------------------
// Radix string calculator datapath
// Operand stores, arithmetic, serial divider and digit shifter.
// ----------------------------------------------------------------------------
module rsc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        base,
    input  rsc_pkg::in_item_t item,
    input  rsc_pkg::dp_cmd_t  cmd,
    output rsc_pkg::dp_stat_t stat,
    output logic [7:0]        digit_out
);
    import rsc_pkg::*;

    logic [WORD_BITS-1:0] first_value_reg, second_value_reg;
    logic first_negative_reg, second_negative_reg;
    logic first_started_reg, second_started_reg, bad_digit_seen_reg;
    logic [WORD_BITS-1:0] a_reg, b_reg;
    logic [1:0] op_reg;
    logic       compute_reg, err_reg, qneg_reg;
    logic [WORD_BITS-1:0] res_reg;
    logic [WORD_BITS-1:0] quo_reg, rem_reg;
    logic [CNT_BITS-1:0]  step_reg;
    logic [WORD_BITS:0]   mag_reg;
    logic [CNT_BITS-1:0]  ndig_reg;
    logic [2:0]           bits_reg;

    logic [2:0]  bits;
    logic [4:0]  dval;
    logic        dok, is_minus;
    logic [WORD_BITS-1:0] a_val, b_val;
    logic [WORD_BITS-1:0] mag_a, mag_b;
    logic [WORD_BITS:0]   rem_shift;
    logic [WORD_BITS:0]   rem_sub;
    logic [WORD_BITS-1:0] r_mag;
    logic [CNT_BITS-1:0]  r_nd;
    logic [3:0]  top_digit;
    logic [3:0]  dmask;

    assign bits = digit_bits(base);
    assign is_minus = (item.char_code == CH_MINUS);

    always_comb
    begin
        dval = 5'd31;
        if (item.char_code >= CH_ZERO && item.char_code <= CH_NINE)
            dval = {1'b0, item.char_code[3:0]};
        else if (item.char_code >= CH_UA && item.char_code <= CH_UF)
            dval = item.char_code[4:0] - 5'd1 + 5'd10;
        dok = (dval < (5'd1 << bits));
    end

    assign a_val = first_negative_reg ? -first_value_reg : first_value_reg;
    assign b_val = second_negative_reg ? -second_value_reg : second_value_reg;
    assign mag_a = a_reg[WORD_BITS-1] ? -a_reg : a_reg;
    assign mag_b = b_reg[WORD_BITS-1] ? -b_reg : b_reg;

    assign rem_shift = {rem_reg, quo_reg[WORD_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, mag_b};

    assign r_mag = res_reg[WORD_BITS-1] ? -res_reg : res_reg;

    // count digits of r_mag: (highest set bit index + 1) / digit width, rounded up
    always_comb
    begin
        r_nd = '0;
        for (int i = 0; i < WORD_BITS; i++)
            if (r_mag[i])
                r_nd = CNT_BITS'(i);
        case (bits_reg)
            3'd1:    r_nd = r_nd + 1'b1;
            // divide by 3 as multiply by 43/128, exact for these counts
            3'd3:    r_nd = CNT_BITS'(((11'(r_nd) + 11'd3) * 11'd43) >> 7);
            default: r_nd = CNT_BITS'((r_nd >> 2) + 1'b1);
        endcase
    end

    assign dmask = (4'd1 << bits_reg) - 4'd1;
    // top digit sits in the upper bits of the left-aligned shifter; one spare
    // bit on top holds the partial leading octal digit
    assign top_digit = mag_reg[WORD_BITS:WORD_BITS-3] >> (3'd4 - bits_reg);
    assign digit_out = digit_char(top_digit & dmask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_value_reg     <= '0;
            second_value_reg    <= '0;
            first_negative_reg  <= 1'b0;
            second_negative_reg <= 1'b0;
            first_started_reg   <= 1'b0;
            second_started_reg  <= 1'b0;
            bad_digit_seen_reg  <= 1'b0;
            compute_reg         <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            compute_reg <= (item.command == CMD_COMPUTE);
            case (item.command)
                CMD_FIRST:
                begin
                    first_started_reg <= 1'b1;
                    if (!first_started_reg && is_minus)
                        first_negative_reg <= 1'b1;
                    else if (!dok)
                        bad_digit_seen_reg <= 1'b1;
                    else
                        first_value_reg <= (first_value_reg << bits) |
                                           WORD_BITS'(dval);
                end
                CMD_SECOND:
                begin
                    second_started_reg <= 1'b1;
                    if (!second_started_reg && is_minus)
                        second_negative_reg <= 1'b1;
                    else if (!dok)
                        bad_digit_seen_reg <= 1'b1;
                    else
                        second_value_reg <= (second_value_reg << bits) |
                                            WORD_BITS'(dval);
                end
                CMD_COMPUTE:
                begin
                    first_value_reg     <= '0;
                    second_value_reg    <= '0;
                    first_negative_reg  <= 1'b0;
                    second_negative_reg <= 1'b0;
                    first_started_reg   <= 1'b0;
                    second_started_reg  <= 1'b0;
                    bad_digit_seen_reg  <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            a_reg    <= a_val;
            b_reg    <= b_val;
            op_reg   <= item.operator_code;
            err_reg  <= bad_digit_seen_reg ||
                        (item.operator_code == OP_DIV && b_val == '0);
            bits_reg <= bits;
            quo_reg  <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (step_reg == '0)
                quo_reg <= mag_a;
            else
            begin
                if (!rem_sub[WORD_BITS])
                begin
                    rem_reg <= rem_sub[WORD_BITS-1:0];
                    quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[WORD_BITS-1:0];
                    quo_reg <= {quo_reg[WORD_BITS-2:0], 1'b0};
                end
            end
            step_reg <= step_reg + 1'b1;
            qneg_reg <= a_reg[WORD_BITS-1] ^ b_reg[WORD_BITS-1];
        end
        else if (cmd.calc)
        begin
            case (op_reg)
                OP_ADD:  res_reg <= a_reg + b_reg;
                OP_SUB:  res_reg <= a_reg - b_reg;
                OP_MUL:  res_reg <= a_reg * b_reg;
                default: res_reg <= qneg_reg ? -quo_reg : quo_reg;
            endcase
            step_reg <= '0;
        end
        else if (cmd.emit_sign || (cmd.emit_digit && step_reg == '0))
        begin
            // first pass: left-align magnitude so the top digit is on top
            mag_reg  <= {1'b0, r_mag} <<
                        (WORD_BITS + 1 - 32'(r_nd) * 32'(bits_reg));
            ndig_reg <= r_nd;
            step_reg <= 1'b1;
        end
        else if (cmd.emit_digit)
        begin
            mag_reg  <= mag_reg << bits_reg;
            ndig_reg <= ndig_reg - 1'b1;
        end
    end

    assign stat.is_compute = compute_reg;
    assign stat.is_div     = (op_reg == OP_DIV);
    assign stat.error      = err_reg;
    assign stat.res_zero   = (res_reg == '0);
    assign stat.res_neg    = res_reg[WORD_BITS-1];
    // one load step plus one step per quotient bit
    assign stat.div_done   = (step_reg == CNT_BITS'(WORD_BITS + 1));
    assign stat.last_digit = (ndig_reg == CNT_BITS'(1));

endmodule

>>> design/rsc_control.sv
// ----------------------------------------------------------------------------
// Radix string calculator controller
// Sequences load, divide, setup and character emission.
// ----------------------------------------------------------------------------
module rsc_control (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rsc_pkg::dp_stat_t stat,
    output rsc_pkg::dp_cmd_t  cmd,
    output logic              strobe,
    output logic              out_last,
    output logic              out_err,
    output logic              out_sel_digit
);
    import rsc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECIDE = 8'b0000_0010,
        ST_DIV    = 8'b0000_0100,
        ST_CALC   = 8'b0000_1000,
        ST_CHECK  = 8'b0001_0000,
        ST_SETUP  = 8'b0010_0000,
        ST_DIGIT  = 8'b0100_0000,
        ST_SIGN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        strobe        = 1'b0;
        out_last      = 1'b0;
        out_err       = 1'b0;
        out_sel_digit = 1'b0;
        busy          = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.is_compute)
                    state_next = ST_IDLE;
                else if (stat.error)
                begin
                    strobe     = 1'b1;
                    out_last   = 1'b1;
                    out_err    = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.is_div)
                    state_next = ST_DIV;
                else
                    state_next = ST_CALC;
            end
            ST_DIV:
            begin
                cmd.div_step = !stat.div_done;
                if (stat.div_done)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.res_zero)
                begin
                    strobe     = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.res_neg)
                begin
                    cmd.emit_sign = 1'b1;
                    strobe        = 1'b1;
                    state_next    = ST_DIGIT;
                end
                else
                begin
                    cmd.emit_digit = 1'b1;
                    state_next     = ST_SETUP;
                end
            end
            ST_SETUP:
                state_next = ST_DIGIT;
            ST_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
                strobe         = 1'b1;
                out_sel_digit  = 1'b1;
                out_last       = stat.last_digit;
                if (stat.last_digit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> busy)
        else $error("busy did not rise after start");
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && out_err) |-> out_last)
        else $error("error beat is not last");
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && out_last) |=> !strobe)
        else $error("beat after last");

endmodule

>>> design/radix_string_calculator.sv
// ----------------------------------------------------------------------------
// Radix string calculator
// Accumulates two signed operands from ASCII digits and prints the result.
// ----------------------------------------------------------------------------
// After its beat is taken, an operand character keeps busy high through the
// decide state. A compute keeps busy high through decide, calculate and each
// emitted character; a positive nonzero result adds check and setup states
// ahead of its digits; an error result leaves from decide. Divide adds the
// bit-serial restoring divider (a load, one quotient bit a cycle, a hand-off).
// Results appear one beat per cycle with strobe high; the receiver cannot
// stall, so every beat must be taken when shown. Configuration is accepted
// whenever busy is low.
module radix_string_calculator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rsc_pkg::in_item_t   item,
    output logic                strobe,
    output rsc_pkg::out_item_t  result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);
    import rsc_pkg::*;

    logic [1:0] base_reg;
    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [7:0] digit_ch;
    logic       out_last, out_err, out_sel_digit;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= BASE_HEX;
        else if (cfg_valid && cfg_ready)
            base_reg <= cfg_data;
    end

    rsc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .base      (base_reg),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .digit_out (digit_ch)
    );

    rsc_control u_ctl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .stat          (stat),
        .cmd           (cmd),
        .strobe        (strobe),
        .out_last      (out_last),
        .out_err       (out_err),
        .out_sel_digit (out_sel_digit)
    );

    always_comb
    begin
        if (out_err)
            result.out_char = 8'd0;
        else if (out_sel_digit)
            result.out_char = digit_ch;
        else if (out_last)
            result.out_char = CH_ZERO;
        else
            result.out_char = CH_MINUS;
        result.last_char  = out_last;
        result.error_flag = out_err;
    end

endmodule

>>> tb/radix_string_calculator_tb.sv
// ----------------------------------------------------------------------------
// Radix string calculator testbench
// Drives operand characters and compute items in every base, predicts the
// printed result of each compute and checks every output beat against it.
// ----------------------------------------------------------------------------
module radix_string_calculator_tb;
    import rsc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] BASE_ALT   = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    logic      strobe;
    out_item_t result;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_data;

    radix_string_calculator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // calculator state mirrored for prediction
    logic [1:0]  base_sel;
    logic [31:0] lhs_acc, rhs_acc;
    logic        lhs_neg, rhs_neg, lhs_begun, rhs_begun, digit_bad;

    in_item_t  pending_items[$];
    out_item_t expected_chars[$];
    int        mismatches;
    int        chars_seen;
    int        computes_sent;
    int        errors_seen;

    function automatic int bits_per_digit(logic [1:0] b);
        case (b)
            BASE_BIN: return 1;
            BASE_OCT: return 3;
            default:  return 4;
        endcase
    endfunction

    function automatic int char_digit(logic [7:0] c, int nb);
        int d;
        d = -1;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_UA && c <= CH_UF)
            d = c - CH_UA + 10;
        if (d >= (1 << nb))
            d = -1;
        return d;
    endfunction

    task automatic accumulate(input logic [7:0] c, inout logic [31:0] acc,
                              inout logic neg, inout logic begun);
        int nb;
        int d;
        nb = bits_per_digit(base_sel);
        if (!begun && c == CH_MINUS)
        begin
            neg   = 1'b1;
            begun = 1'b1;
            return;
        end
        begun = 1'b1;
        d = char_digit(c, nb);
        if (d < 0)
            digit_bad = 1'b1;
        else
            acc = (acc << nb) | 32'(d);
    endtask

    function automatic logic [7:0] to_ascii(int d);
        return (d < 10) ? CH_ZERO + 8'(d) : CH_UA + 8'(d - 10);
    endfunction

    task automatic predict_compute(input logic [1:0] op);
        logic [31:0] a, b, r, mag;
        logic        fail;
        logic [7:0]  digs[$];
        int          nb;
        out_item_t   o;
        a    = lhs_neg ? -lhs_acc : lhs_acc;
        b    = rhs_neg ? -rhs_acc : rhs_acc;
        fail = digit_bad;
        nb   = bits_per_digit(base_sel);
        lhs_acc = '0; rhs_acc = '0; lhs_neg = 1'b0; rhs_neg = 1'b0;
        lhs_begun = 1'b0; rhs_begun = 1'b0; digit_bad = 1'b0;
        r = '0;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            default:
            begin
                if (b == '0)
                    fail = 1'b1;
                else
                begin
                    r = (a[31] ? -a : a) / (b[31] ? -b : b);
                    if (a[31] ^ b[31])
                        r = -r;
                end
            end
        endcase
        computes_sent++;
        if (fail)
        begin
            o = '{out_char: 8'h00, last_char: 1'b1, error_flag: 1'b1};
            expected_chars.push_back(o);
            return;
        end
        if (r == '0)
        begin
            o = '{out_char: CH_ZERO, last_char: 1'b1, error_flag: 1'b0};
            expected_chars.push_back(o);
            return;
        end
        mag = r[31] ? -r : r;
        while (mag != '0)
        begin
            digs.push_front(to_ascii(int'(mag & ((32'd1 << nb) - 1))));
            mag = mag >> nb;
        end
        if (r[31])
            expected_chars.push_back('{out_char: CH_MINUS, last_char: 1'b0,
                                       error_flag: 1'b0});
        foreach (digs[i])
            expected_chars.push_back('{out_char: digs[i],
                                       last_char: (i == digs.size() - 1),
                                       error_flag: 1'b0});
    endtask

    task automatic apply_item(input in_item_t it);
        case (it.command)
            CMD_FIRST:   accumulate(it.char_code, lhs_acc, lhs_neg, lhs_begun);
            CMD_SECOND:  accumulate(it.char_code, rhs_acc, rhs_neg, rhs_begun);
            CMD_COMPUTE: predict_compute(it.operator_code);
            default: ;
        endcase
    endtask

    // ---------------- driver ----------------
    int        gap_left;
    logic      busy_at_edge;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else if (start && !busy_at_edge)
        begin
            // beat taken at the last rising edge
            start    <= 1'b0;
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        end
        else if (!start && pending_items.size() > 0)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else
            begin
                item  <= pending_items.pop_front();
                start <= 1'b1;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        busy_at_edge <= busy;
        if (rst_n && start && !busy)
            apply_item(item);
        if (rst_n && strobe)
        begin
            chars_seen++;
            if (result.error_flag)
                errors_seen++;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output beat char=%h last=%b err=%b",
                             result.out_char, result.last_char,
                             result.error_flag);
            end
            else
            begin
                out_item_t e;
                e = expected_chars.pop_front();
                if (e !== result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected char=%h last=%b err=%b,",
                                  " got char=%h last=%b err=%b"},
                                 e.out_char, e.last_char, e.error_flag,
                                 result.out_char, result.last_char,
                                 result.error_flag);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic in_item_t make_item(logic [1:0] cmd, logic [7:0] c,
                                           logic [1:0] op);
        in_item_t it;
        it.command       = cmd;
        it.char_code     = c;
        it.operator_code = op;
        return it;
    endfunction

    function automatic logic [7:0] random_digit(logic [1:0] b);
        int nb;
        nb = bits_per_digit(b);
        return to_ascii($urandom_range(0, (1 << nb) - 1));
    endfunction

    task automatic queue_operand(input logic [1:0] cmd, input logic [1:0] b,
                                 input int len, input logic neg);
        if (neg)
            pending_items.push_back(make_item(cmd, CH_MINUS, 2'($urandom)));
        repeat (len)
            pending_items.push_back(make_item(cmd, random_digit(b),
                                              2'($urandom)));
    endtask

    task automatic drain_and_wait();
        while (pending_items.size() > 0 || start || expected_chars.size() > 0)
            @(posedge clk);
        // let the block settle back to idle
        repeat (60) @(posedge clk);
    endtask

    task automatic write_base(input logic [1:0] b);
        @(negedge clk);
        cfg_data  <= b;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        base_sel = b;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [1:0] b, input int n);
        int k;
        int lmax;
        lmax = 32 / bits_per_digit(b) + 2;
        k = 0;
        while (k < n)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // noise: any character or command
                    repeat ($urandom_range(1, 3))
                    begin
                        pending_items.push_back(make_item(2'($urandom),
                                                          8'($urandom),
                                                          2'($urandom)));
                        k++;
                    end
                end
                1:
                begin
                    queue_operand(CMD_FIRST, b, $urandom_range(0, 3), 1'b0);
                    pending_items.push_back(make_item(CMD_FIRST,
                        $urandom_range(0, 1) ? CH_MINUS : 8'h61, 2'd0));
                    pending_items.push_back(make_item(CMD_COMPUTE, 8'd0,
                                                      2'($urandom)));
                    k += 4;
                end
                default:
                begin
                    int la, lb;
                    la = ($urandom_range(0, 4) == 0) ? lmax : $urandom_range(0, 4);
                    lb = ($urandom_range(0, 4) == 0) ? lmax : $urandom_range(0, 3);
                    queue_operand(CMD_FIRST, b, la, $urandom_range(0, 2) == 0);
                    queue_operand(CMD_SECOND, b, lb, $urandom_range(0, 2) == 0);
                    pending_items.push_back(make_item(CMD_COMPUTE, 8'd0,
                                                      2'($urandom)));
                    k += la + lb + 1;
                end
            endcase
            drain_and_wait();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        busy_at_edge = 1'b0;
        gap_left  = 0;
        mismatches = 0;
        chars_seen = 0;
        computes_sent = 0;
        errors_seen = 0;
        base_sel = BASE_HEX;
        lhs_acc = '0; rhs_acc = '0; lhs_neg = 1'b0; rhs_neg = 1'b0;
        lhs_begun = 1'b0; rhs_begun = 1'b0; digit_bad = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: hex at reset value
        // most negative: 80000000 printed as unsigned magnitude
        pending_items.push_back(make_item(CMD_FIRST, CH_MINUS, OP_ADD));
        pending_items.push_back(make_item(CMD_FIRST, "8", OP_ADD));
        repeat (7) pending_items.push_back(make_item(CMD_FIRST, CH_ZERO, OP_ADD));
        pending_items.push_back(make_item(CMD_SECOND, CH_MINUS, OP_ADD));
        pending_items.push_back(make_item(CMD_SECOND, "1", OP_ADD));
        pending_items.push_back(make_item(CMD_COMPUTE, 8'hFF, OP_DIV));
        // divide by zero, empty operands
        pending_items.push_back(make_item(CMD_COMPUTE, 8'd0, OP_DIV));
        // zero result and unused command ignored
        pending_items.push_back(make_item(CMD_UNUSED, 8'hFF, OP_DIV));
        pending_items.push_back(make_item(CMD_COMPUTE, 8'd0, OP_ADD));
        // lower case letter and late minus are invalid
        pending_items.push_back(make_item(CMD_FIRST, "F", OP_ADD));
        pending_items.push_back(make_item(CMD_FIRST, "f", OP_ADD));
        pending_items.push_back(make_item(CMD_COMPUTE, 8'd0, OP_MUL));
        pending_items.push_back(make_item(CMD_SECOND, "A", OP_ADD));
        pending_items.push_back(make_item(CMD_SECOND, CH_MINUS, OP_ADD));
        pending_items.push_back(make_item(CMD_COMPUTE, 8'd0, OP_SUB));
        drain_and_wait();
        // binary: digit 2 is invalid, then a lone minus reads as zero
        write_base(BASE_BIN);
        pending_items.push_back(make_item(CMD_FIRST, CH_MINUS, OP_ADD));
        pending_items.push_back(make_item(CMD_FIRST, "1", OP_ADD));
        pending_items.push_back(make_item(CMD_SECOND, CH_MINUS, OP_ADD));
        pending_items.push_back(make_item(CMD_SECOND, "2", OP_ADD));
        pending_items.push_back(make_item(CMD_COMPUTE, 8'd0, OP_SUB));
        pending_items.push_back(make_item(CMD_FIRST, CH_MINUS, OP_ADD));
        pending_items.push_back(make_item(CMD_COMPUTE, 8'd0, OP_SUB));
        drain_and_wait();

        random_phase(BASE_BIN, 100);
        write_base(BASE_OCT);
        random_phase(BASE_OCT, 110);
        write_base(BASE_HEX);
        random_phase(BASE_HEX, 110);
        write_base(BASE_ALT);
        random_phase(BASE_ALT, 60);

        $display("Sent %0d computes over all four base codes;", computes_sent);
        $display("checked %0d output beats, %0d of them errors.",
                 chars_seen, errors_seen);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

endmodule
